FILE: hdl/pdh_pkg.sv
// Shared types and defaults for the dice generator with histogram.
// No dependencies; imported by pdh_ctrl, pdh_datapath and prng_dice_histogram_top.
`timescale 1ns / 1ps
`default_nettype none

package pdh_pkg;

	localparam int MAX_FACES_DEF   = 32;
	localparam int COUNT_WIDTH_DEF = 48;

	localparam int FACES_W   = 6;
	localparam int SEED_W    = 64;
	localparam int FUNC_W    = 2;
	localparam int BIN_IDX_W = 5;
	localparam int ROLL_W    = 5;
	localparam int OUT_CNT_W = 48;
	localparam int DEV_W     = 58;

	localparam logic [FACES_W-1:0] FACES_RESET = 6'd32;
	localparam logic [SEED_W-1:0]  SEED_RESET  = 64'd1;

	typedef struct packed {
		logic [FUNC_W-1:0]    func;
		logic [BIN_IDX_W-1:0] bin_index;
	} req_t;

	typedef struct packed {
		logic [ROLL_W-1:0]    roll_value;
		logic [OUT_CNT_W-1:0] bin_count;
		logic [OUT_CNT_W-1:0] sum_values;
		logic [DEV_W-1:0]     sum_sq_dev;
	} rsp_t;

	// controller -> datapath commands
	typedef struct packed {
		logic mul;        // partial products of the generator state
		logic square;     // fold partial products into the low 64 bits of the square
		logic advance;    // state += square | 5
		logic scale;      // face = (hi32 * F) >> 32, latch bin address
		logic load_idx;   // latch bin address from the read request
		logic fetch;      // histogram read, deviation square
		logic upd_roll;   // bin write-back, sums, roll result
		logic upd_read;   // read result
		logic restart;    // load seed, clear histogram and sums
		logic emit_zero;  // all-zero result
	} dp_cmd_t;

endpackage

`default_nettype wire

FILE: hdl/prng_dice_histogram_top.sv
// Top level of the dice generator with face histogram and running statistics.
// Depends on pdh_pkg, pdh_ctrl and pdh_datapath.
`timescale 1ns / 1ps
`default_nettype none

// Channel    Signals                          Transfer
// request    start, busy, req (func, bin)     edge with start high and busy low
// result     done, rsp (roll, count, sums)    every edge ending a cycle with done high
// config     cfg_we, cfg_index, cfg_wdata     every edge with cfg_we high
//
// Roll: busy until write-back; the chain is two 32x32 partial products, a
//   32-bit fold into the square, the 64-bit state add, the 32x6 scaling
//   multiply, a registered histogram read, then write-back and sums.
// Read: address latch, registered memory read, result.
// Restart and the unused code: result on the next cycle, busy stays low.
// Reset clears the histogram at once through per-bin valid bits.
// The result shows for one cycle with done; the receiver cannot stall it.

module prng_dice_histogram_top #(
	parameter int MAX_FACES   = pdh_pkg::MAX_FACES_DEF,
	parameter int COUNT_WIDTH = pdh_pkg::COUNT_WIDTH_DEF
) (
	input  wire logic                       clk,
	input  wire logic                       arst_n,
	input  wire logic                       start,
	output logic                            busy,
	input  wire pdh_pkg::req_t              req,
	output logic                            done,
	output pdh_pkg::rsp_t                   rsp,
	input  wire logic                       cfg_we,
	input  wire logic                       cfg_index,
	input  wire logic [pdh_pkg::SEED_W-1:0] cfg_wdata
);
	import pdh_pkg::*;

	// one command bundle per cycle from the sequencer
	dp_cmd_t cmd;

	pdh_ctrl u_ctrl (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (start),
		.func   (req.func),
		.busy   (busy),
		.cmd    (cmd)
	);

	// generator, histogram and sums; config registers live here as well
	pdh_datapath #(
		.MAX_FACES   (MAX_FACES),
		.COUNT_WIDTH (COUNT_WIDTH)
	) u_datapath (
		.clk       (clk),
		.arst_n    (arst_n),
		.cmd       (cmd),
		.req       (req),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_wdata (cfg_wdata),
		.done      (done),
		.rsp       (rsp)
	);

endmodule

`default_nettype wire

FILE: hdl/pdh_ctrl.sv
// Sequencer for the dice generator: decodes requests, steps the datapath.
// Depends on pdh_pkg.
`timescale 1ns / 1ps
`default_nettype none

module pdh_ctrl (
	input  wire logic                     clk,
	input  wire logic                     arst_n,
	input  wire logic                     start,
	input  wire logic [pdh_pkg::FUNC_W-1:0] func,
	output logic                          busy,
	output pdh_pkg::dp_cmd_t              cmd
);
	import pdh_pkg::*;

	localparam logic [FUNC_W-1:0] FUNC_ROLL    = 2'd0;
	localparam logic [FUNC_W-1:0] FUNC_READ    = 2'd1;
	localparam logic [FUNC_W-1:0] FUNC_RESTART = 2'd2;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_SQUARE,
		ST_ADVANCE,
		ST_SCALE,
		ST_FETCH,
		ST_UPDATE,
		ST_RD_FETCH,
		ST_RD_OUT
	} state_t;

	state_t state_q;
	logic   accept;

	assign busy   = (state_q != ST_IDLE);
	assign accept = start && (state_q == ST_IDLE);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			unique case (state_q)
				ST_IDLE: begin
					if (accept) begin
						if (func == FUNC_ROLL) begin
							state_q <= ST_SQUARE;
						end else if (func == FUNC_READ) begin
							state_q <= ST_RD_FETCH;
						end
					end
				end
				ST_SQUARE:   state_q <= ST_ADVANCE;
				ST_ADVANCE:  state_q <= ST_SCALE;
				ST_SCALE:    state_q <= ST_FETCH;
				ST_FETCH:    state_q <= ST_UPDATE;
				ST_UPDATE:   state_q <= ST_IDLE;
				ST_RD_FETCH: state_q <= ST_RD_OUT;
				ST_RD_OUT:   state_q <= ST_IDLE;
			endcase
		end
	end

	always_comb begin
		cmd = '0;
		unique case (state_q)
			ST_IDLE: begin
				if (accept) begin
					unique case (func)
						FUNC_ROLL:    cmd.mul = 1'b1;
						FUNC_READ:    cmd.load_idx = 1'b1;
						FUNC_RESTART: begin
							cmd.restart   = 1'b1;
							cmd.emit_zero = 1'b1;
						end
						default:      cmd.emit_zero = 1'b1;
					endcase
				end
			end
			ST_SQUARE:   cmd.square   = 1'b1;
			ST_ADVANCE:  cmd.advance  = 1'b1;
			ST_SCALE:    cmd.scale    = 1'b1;
			ST_FETCH:    cmd.fetch    = 1'b1;
			ST_UPDATE:   cmd.upd_roll = 1'b1;
			ST_RD_FETCH: cmd.fetch    = 1'b1;
			ST_RD_OUT:   cmd.upd_read = 1'b1;
		endcase
	end

	// at most one datapath step per cycle (restart rides with its zero result)
	a_one_step: assert property (@(posedge clk) disable iff (!arst_n)
		$onehot0({cmd.mul, cmd.square, cmd.advance, cmd.scale, cmd.load_idx,
			cmd.fetch, cmd.upd_roll, cmd.upd_read, cmd.emit_zero}))
		else $error("pdh_ctrl: more than one datapath step issued");

	// a roll walks the full chain: every update follows a scale, with the fetch state between them
	a_roll_chain: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.upd_roll |-> $past(cmd.scale, 2))
		else $error("pdh_ctrl: roll update without a preceding scale");

endmodule

`default_nettype wire

FILE: hdl/pdh_datapath.sv
// Generator, face scaling, histogram memory, saturating sums, result register.
// Depends on pdh_pkg; stepped by pdh_ctrl through dp_cmd_t.
`timescale 1ns / 1ps
`default_nettype none

module pdh_datapath #(
	parameter int MAX_FACES   = pdh_pkg::MAX_FACES_DEF,
	parameter int COUNT_WIDTH = pdh_pkg::COUNT_WIDTH_DEF
) (
	input  wire logic                          clk,
	input  wire logic                          arst_n,
	input  wire pdh_pkg::dp_cmd_t              cmd,
	input  wire pdh_pkg::req_t                 req,
	input  wire logic                          cfg_we,
	input  wire logic                          cfg_index,
	input  wire logic [pdh_pkg::SEED_W-1:0]    cfg_wdata,
	output logic                               done,
	output pdh_pkg::rsp_t                      rsp
);
	import pdh_pkg::*;

	localparam int  AW        = (MAX_FACES > 1) ? $clog2(MAX_FACES) : 1;
	localparam int  CW        = COUNT_WIDTH;
	localparam int  FCAP      = (MAX_FACES < 63) ? MAX_FACES : 63;
	localparam int  SQ_W      = 13;
	localparam logic REG_FACES = 1'b0;
	localparam logic REG_SEED  = 1'b1;

	// configuration
	logic [FACES_W-1:0] faces_q;
	logic [SEED_W-1:0]  seed_q;

	// generator
	logic [SEED_W-1:0]  gen_q;
	logic [63:0]        pll_s1;
	logic [31:0]        phl_s1;
	logic [63:0]        sq_s2;

	// scaling
	logic [FACES_W-1:0] f_eff;
	logic [37:0]        scale_prod;
	logic [FACES_W-1:0] face_s3;
	logic [FACES_W-1:0] f_s3;
	logic [AW-1:0]      addr_q;
	logic               in_range_q;

	// histogram
	logic [CW-1:0]        hist_mem [MAX_FACES];
	logic [MAX_FACES-1:0] valid_q;
	logic [CW-1:0]        rd_s4;
	logic                 rd_valid_s4;

	// deviation
	logic signed [7:0]  dev;
	logic [6:0]         dev_mag;
	logic [SQ_W-1:0]    devsq_s4;

	// sums
	logic [CW-1:0]      vs_q;
	logic [DEV_W-1:0]   ds_q;
	logic [CW-1:0]      cnt_cur;
	logic [CW-1:0]      cnt_new;
	logic [CW:0]        vs_sum;
	logic [CW-1:0]      vs_new;
	logic [DEV_W:0]     ds_sum;
	logic [DEV_W-1:0]   ds_new;

	logic               done_q;
	rsp_t               rsp_q;

	assign f_eff      = (32'(faces_q) > FCAP) ? 6'(FCAP) : faces_q;
	assign scale_prod = {6'b0, gen_q[63:32]} * {32'b0, f_eff};

	assign dev     = $signed({1'b0, face_s3, 1'b0}) - $signed({2'b00, f_s3}) - 8'sd1;
	assign dev_mag = dev[7] ? 7'(-dev) : 7'(dev);

	assign cnt_cur = rd_valid_s4 ? rd_s4 : '0;
	assign cnt_new = (&cnt_cur) ? cnt_cur : cnt_cur + {{(CW-1){1'b0}}, 1'b1};

	assign vs_sum = {1'b0, vs_q} + {{(CW+1-FACES_W){1'b0}}, face_s3};
	assign vs_new = vs_sum[CW] ? '1 : vs_sum[CW-1:0];
	assign ds_sum = {1'b0, ds_q} + {{(DEV_W+1-SQ_W){1'b0}}, devsq_s4};
	assign ds_new = ds_sum[DEV_W] ? '1 : ds_sum[DEV_W-1:0];

	// configuration, generator state, bin valid bits, sums and done
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			faces_q <= FACES_RESET;
			seed_q  <= SEED_RESET;
			gen_q   <= SEED_RESET;
			valid_q <= '0;
			vs_q    <= '0;
			ds_q    <= '0;
			done_q  <= 1'b0;
		end else begin
			if (cfg_we && cfg_index == REG_FACES) begin
				faces_q <= cfg_wdata[FACES_W-1:0];
			end
			if (cfg_we && cfg_index == REG_SEED) begin
				seed_q <= cfg_wdata;
			end
			if (cmd.restart) begin
				gen_q   <= seed_q;
				valid_q <= '0;
				vs_q    <= '0;
				ds_q    <= '0;
			end else if (cmd.advance) begin
				gen_q <= gen_q + (sq_s2 | 64'd5);
			end else if (cmd.upd_roll) begin
				valid_q[addr_q] <= 1'b1;
				vs_q            <= vs_new;
				ds_q            <= ds_new;
			end
			done_q <= cmd.upd_roll || cmd.upd_read || cmd.emit_zero;
		end
	end

	// pipeline payload, histogram memory and result register
	always_ff @(posedge clk) begin
		if (cmd.mul) begin
			pll_s1 <= {32'b0, gen_q[31:0]} * {32'b0, gen_q[31:0]};
			phl_s1 <= 32'(gen_q[63:32] * gen_q[31:0]);
		end
		if (cmd.square) begin
			// low 64 bits of (h*2^32 + l)^2 = l*l + 2*h*l*2^32
			sq_s2 <= {pll_s1[63:32] + {phl_s1[30:0], 1'b0}, pll_s1[31:0]};
		end
		if (cmd.scale) begin
			face_s3    <= scale_prod[37:32];
			f_s3       <= f_eff;
			addr_q     <= AW'(scale_prod[37:32]);
			in_range_q <= 1'b1;
		end else if (cmd.load_idx) begin
			face_s3    <= '0;
			f_s3       <= '0;
			addr_q     <= AW'(req.bin_index);
			in_range_q <= (32'(req.bin_index) < MAX_FACES);
		end
		if (cmd.fetch) begin
			rd_s4       <= hist_mem[addr_q];
			rd_valid_s4 <= valid_q[addr_q] && in_range_q;
			devsq_s4    <= {6'b0, dev_mag} * {6'b0, dev_mag};
		end
		if (cmd.upd_roll) begin
			hist_mem[addr_q] <= cnt_new;
		end
		if (cmd.upd_roll) begin
			rsp_q.roll_value <= ROLL_W'(face_s3);
			rsp_q.bin_count  <= OUT_CNT_W'(cnt_new);
			rsp_q.sum_values <= OUT_CNT_W'(vs_new);
			rsp_q.sum_sq_dev <= ds_new;
		end else if (cmd.upd_read) begin
			rsp_q.roll_value <= '0;
			rsp_q.bin_count  <= OUT_CNT_W'(cnt_cur);
			rsp_q.sum_values <= OUT_CNT_W'(vs_q);
			rsp_q.sum_sq_dev <= ds_q;
		end else if (cmd.emit_zero) begin
			rsp_q <= '0;
		end
	end

	assign done = done_q;
	assign rsp  = rsp_q;

	a_done_cause: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> $past(cmd.upd_roll || cmd.upd_read || cmd.emit_zero))
		else $error("pdh_datapath: result strobe without an update");

	a_restart_zero: assert property (@(posedge clk) disable iff (!arst_n)
		(done && $past(cmd.restart)) |-> (rsp == '0))
		else $error("pdh_datapath: restart result not all zero");

	a_face_range: assert property (@(posedge clk) disable iff (!arst_n)
		$past(cmd.scale) |-> (face_s3 < f_s3 || face_s3 == '0))
		else $error("pdh_datapath: scaled face outside the die");

	a_sum_mono: assert property (@(posedge clk) disable iff (!arst_n)
		!$past(cmd.restart) |-> (vs_q >= $past(vs_q) && ds_q >= $past(ds_q)))
		else $error("pdh_datapath: running sum decreased without restart");

endmodule

`default_nettype wire
